// ===== src/lvm_pkg.sv =====
// Package for the look-at view matrix block: payload structs, command codes,
// the multiply-accumulate program decoder and saturation helper. No dependencies.
package lvm_pkg;

  typedef struct packed {
    logic               mode;
    logic        [3:0]  element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lvm_in_t;

  typedef struct packed {
    logic        [3:0]  out_index;
    logic signed [31:0] out_value;
    logic               degenerate;
    logic               last;
  } lvm_out_t;

  typedef enum logic [2:0] {OPA_AMAG, OPA_F, OPA_S, OPA_M, OPA_R} opa_sel_e;
  typedef enum logic [2:0] {
    OPB_AMAG, OPB_UP, OPB_F, OPB_S, OPB_U, OPB_NEYE, OPB_ONE
  } opb_sel_e;
  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADDRND} acc_op_e;
  typedef enum logic [1:0] {WR_C, WR_U, WR_R, WR_RT} wr_sel_e;
  typedef enum logic [1:0] {K_MUL, K_WR, K_LDR} mac_kind_e;
  typedef enum logic [2:0] {PROG_SQ, PROG_CROSS, PROG_UP, PROG_MM, PROG_TR} prog_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_IN_LOAD, DP_NRM_INIT, DP_NRM_SHIFT, DP_NRM_ZERO, DP_MUL, DP_ACC,
    DP_LDR, DP_WR, DP_SQRT_INIT, DP_SQRT_STEP, DP_DIV_INIT, DP_DIV_STEP,
    DP_DIV_WR, DP_COPY, DP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NINIT, S_NSHIFT, S_MAC, S_SQRT_INIT, S_SQRT, S_DINIT, S_DIV,
    S_DWR, S_COPY, S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    mac_kind_e  kind;
    opa_sel_e   a_sel;
    opb_sel_e   b_sel;
    logic [1:0] aidx;
    logic [1:0] bidx;
    logic [3:0] mat;
    acc_op_e    acc_op;
    wr_sel_e    wr_sel;
    logic       end_grp;
    logic       last;
  } mac_op_t;

  typedef struct packed {
    dp_op_e     op;
    mac_op_t    mac;
    logic [1:0] vidx;
    logic       dst_s;
    logic [3:0] emit_idx;
  } lvm_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic in_range;
    logic out_free;
  } lvm_stat_t;

  localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > SAT_MAX) return 32'sh7fffffff;
    if (v < SAT_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  // Decode one step of a multiply-accumulate program.
  function automatic mac_op_t mac_decode(input prog_e prog, input logic [3:0] grp,
                                         input logic [2:0] sub);
    mac_op_t    o;
    logic [1:0] i;
    logic [1:0] p;
    logic [1:0] q;
    logic [1:0] col;
    logic [1:0] j;
    o   = '0;
    i   = grp[1:0];
    p   = nxt3(i);
    q   = nxt3(p);
    col = grp[3:2];
    j   = sub[1:0] - 2'd1;
    case (prog)
      PROG_SQ: begin
        o.a_sel   = OPA_AMAG;
        o.b_sel   = OPB_AMAG;
        o.aidx    = i;
        o.bidx    = i;
        o.acc_op  = (i == 2'd0) ? ACC_LOAD : ACC_ADD;
        o.end_grp = 1'b1;
        o.last    = (i == 2'd2);
      end
      PROG_CROSS, PROG_UP: begin
        o.a_sel = (prog == PROG_CROSS) ? OPA_F : OPA_S;
        o.b_sel = (prog == PROG_CROSS) ? OPB_UP : OPB_F;
        case (sub)
          3'd0: begin
            o.aidx   = p;
            o.bidx   = q;
            o.acc_op = ACC_LOAD;
          end
          3'd1: begin
            o.aidx   = q;
            o.bidx   = p;
            o.acc_op = ACC_SUB;
          end
          default: begin
            o.kind    = K_WR;
            o.aidx    = i;
            o.wr_sel  = (prog == PROG_CROSS) ? WR_C : WR_U;
            o.end_grp = 1'b1;
            o.last    = (i == 2'd2);
          end
        endcase
      end
      PROG_MM: begin
        o.a_sel = OPA_M;
        o.bidx  = col;
        if (col != 2'd3) begin
          case (sub)
            3'd0: begin
              o.mat    = {2'd0, i};
              o.b_sel  = OPB_S;
              o.acc_op = ACC_LOAD;
            end
            3'd1: begin
              o.mat    = {2'd1, i};
              o.b_sel  = OPB_U;
              o.acc_op = ACC_ADD;
            end
            3'd2: begin
              o.mat    = {2'd2, i};
              o.b_sel  = OPB_F;
              o.acc_op = ACC_SUB;
            end
            default: begin
              o.kind    = K_WR;
              o.mat     = grp;
              o.wr_sel  = WR_R;
              o.end_grp = 1'b1;
            end
          endcase
        end else begin
          case (sub)
            3'd0: begin
              o.mat    = {2'd3, i};
              o.b_sel  = OPB_ONE;
              o.acc_op = ACC_LOAD;
            end
            default: begin
              o.kind    = K_WR;
              o.mat     = grp;
              o.wr_sel  = WR_R;
              o.end_grp = 1'b1;
              o.last    = (i == 2'd3);
            end
          endcase
        end
      end
      PROG_TR: begin
        case (sub)
          3'd0: begin
            o.kind = K_LDR;
            o.mat  = {2'd3, i};
          end
          3'd1, 3'd2, 3'd3: begin
            o.a_sel  = OPA_R;
            o.b_sel  = OPB_NEYE;
            o.mat    = {j, i};
            o.bidx   = j;
            o.acc_op = ACC_ADDRND;
          end
          default: begin
            o.kind    = K_WR;
            o.mat     = {2'd3, i};
            o.wr_sel  = WR_RT;
            o.end_grp = 1'b1;
            o.last    = (i == 2'd3);
          end
        endcase
      end
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

// ===== src/lvm_ctrl.sv =====
// Sequencer for the look-at view matrix block: issues datapath commands.
// Depends on lvm_pkg.
module lvm_ctrl import lvm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_mode_i,
  input  lvm_stat_t st_i,
  output logic      in_stall_o,
  output lvm_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  prog_e       prog_q, prog_d;
  logic [3:0]  grp_q, grp_d;
  logic [2:0]  sub_q, sub_d;
  logic        ph_q, ph_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  vi_q, vi_d;
  logic        nsel_q, nsel_d;
  logic [3:0]  emit_q, emit_d;
  mac_op_t     op;

  assign op = mac_decode(prog_q, grp_q, sub_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prog_q  <= PROG_SQ;
      grp_q   <= '0;
      sub_q   <= '0;
      ph_q    <= 1'b0;
      cnt_q   <= '0;
      vi_q    <= '0;
      nsel_q  <= 1'b0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      prog_q  <= prog_d;
      grp_q   <= grp_d;
      sub_q   <= sub_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      vi_q    <= vi_d;
      nsel_q  <= nsel_d;
      emit_q  <= emit_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    prog_d  = prog_q;
    grp_d   = grp_q;
    sub_d   = sub_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    vi_d    = vi_q;
    nsel_d  = nsel_q;
    emit_d  = emit_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_mode_i) begin
          state_d = S_NINIT;
          nsel_d  = 1'b0;
        end
      end
      S_NINIT: state_d = S_NSHIFT;
      S_NSHIFT: begin
        if (st_i.a_zero) begin
          state_d = S_MAC;
          prog_d  = nsel_q ? PROG_UP : PROG_CROSS;
          grp_d   = '0;
          sub_d   = '0;
          ph_d    = 1'b0;
        end else if (st_i.in_range) begin
          state_d = S_MAC;
          prog_d  = PROG_SQ;
          grp_d   = '0;
          sub_d   = '0;
          ph_d    = 1'b0;
        end
      end
      S_MAC: begin
        if (op.kind == K_MUL && !ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (op.last) begin
            grp_d = '0;
            sub_d = '0;
            case (prog_q)
              PROG_SQ:    state_d = S_SQRT_INIT;
              PROG_CROSS: begin
                state_d = S_NINIT;
                nsel_d  = 1'b1;
              end
              PROG_UP:    prog_d = PROG_MM;
              PROG_MM:    prog_d = PROG_TR;
              default:    state_d = S_COPY;
            endcase
          end else if (op.end_grp) begin
            grp_d = grp_q + 4'd1;
            sub_d = '0;
          end else begin
            sub_d = sub_q + 3'd1;
          end
        end
      end
      S_SQRT_INIT: begin
        cnt_d   = 5'd31;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (cnt_q == '0) begin
          state_d = S_DINIT;
          vi_d    = '0;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_DINIT: begin
        cnt_d   = 5'(FRAC_BITS);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == '0) state_d = S_DWR;
        else cnt_d = cnt_q - 5'd1;
      end
      S_DWR: begin
        if (vi_q == 2'd2) begin
          state_d = S_MAC;
          prog_d  = nsel_q ? PROG_UP : PROG_CROSS;
          grp_d   = '0;
          sub_d   = '0;
          ph_d    = 1'b0;
        end else begin
          vi_d    = vi_q + 2'd1;
          state_d = S_DINIT;
        end
      end
      S_COPY: begin
        state_d = S_EMIT;
        emit_d  = '0;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          emit_d = emit_q + 4'd1;
          if (emit_q == 4'd15) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = DP_NOP;
    cmd_o.mac      = op;
    cmd_o.vidx     = vi_q;
    cmd_o.dst_s    = nsel_q;
    cmd_o.emit_idx = emit_q;
    in_stall_o     = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE:      if (in_valid_i) cmd_o.op = DP_IN_LOAD;
      S_NINIT:     cmd_o.op = DP_NRM_INIT;
      S_NSHIFT: begin
        if (st_i.a_zero) cmd_o.op = DP_NRM_ZERO;
        else if (!st_i.in_range) cmd_o.op = DP_NRM_SHIFT;
      end
      S_MAC: begin
        unique case (op.kind)
          K_MUL:   cmd_o.op = ph_q ? DP_ACC : DP_MUL;
          K_WR:    cmd_o.op = DP_WR;
          K_LDR:   cmd_o.op = DP_LDR;
          default: cmd_o.op = DP_NOP;
        endcase
      end
      S_SQRT_INIT: cmd_o.op = DP_SQRT_INIT;
      S_SQRT:      cmd_o.op = DP_SQRT_STEP;
      S_DINIT:     cmd_o.op = DP_DIV_INIT;
      S_DIV:       cmd_o.op = DP_DIV_STEP;
      S_DWR:       cmd_o.op = DP_DIV_WR;
      S_COPY:      cmd_o.op = DP_COPY;
      S_EMIT:      if (st_i.out_free) cmd_o.op = DP_EMIT;
      default:     cmd_o.op = DP_NOP;
    endcase
  end

endmodule

// ===== src/lvm_datapath.sv =====
// Datapath for the look-at view matrix block: base and result matrices,
// shared multiplier and accumulator, square root and divider steps.
// Depends on lvm_pkg.
module lvm_datapath import lvm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lvm_in_t   in_data_i,
  input  lvm_cmd_t  cmd_i,
  input  logic      out_stall_i,
  output lvm_stat_t st_o,
  output logic      out_valid_o,
  output lvm_out_t  out_data_o
);

  localparam logic signed [31:0] ONE32   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] ONE34   = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [67:0] HALF68  = 68'sd1 <<< (FRAC_BITS - 1);
  localparam logic        [63:0] BIT0    = 64'd1 << 62;

  logic signed [31:0] m_q [16];
  logic signed [31:0] r_q [16];
  logic signed [31:0] eye_q [3];
  logic signed [31:0] up_q [3];
  logic signed [63:0] v_q [3];
  logic        [63:0] a_q [3];
  logic        [2:0]  sgn_q;
  logic signed [31:0] f_q [3];
  logic signed [31:0] s_q [3];
  logic signed [31:0] u_q [3];
  logic signed [67:0] prod_q;
  logic signed [67:0] acc_q;
  logic        [63:0] x_q, root_q, bit_q;
  logic        [63:0] rem_q, dsh_q;
  logic        [31:0] quo_q;
  logic               degen_q;
  lvm_out_t           out_q;
  logic               out_valid_q;

  logic        [63:0] or_v;
  logic signed [33:0] opa, opb;
  logic signed [67:0] mul_w;
  logic signed [67:0] acc_rnd, prod_rnd;
  logic        [63:0] sq_t;
  logic signed [31:0] quo_s;
  logic        [3:0]  rd_idx;
  logic signed [31:0] r_rd;

  assign or_v        = a_q[0] | a_q[1] | a_q[2];
  assign st_o.a_zero   = (or_v == '0);
  assign st_o.in_range = !(|or_v[63:30]) && or_v[29];
  assign st_o.out_free = !out_valid_q || !out_stall_i;

  assign rd_idx = (cmd_i.op == DP_EMIT) ? cmd_i.emit_idx : cmd_i.mac.mat;
  assign r_rd   = r_q[rd_idx];

  always_comb begin
    case (cmd_i.mac.a_sel)
      OPA_AMAG: opa = {4'b0, a_q[cmd_i.mac.aidx][29:0]};
      OPA_F:    opa = 34'(f_q[cmd_i.mac.aidx]);
      OPA_S:    opa = 34'(s_q[cmd_i.mac.aidx]);
      OPA_M:    opa = 34'(m_q[cmd_i.mac.mat]);
      OPA_R:    opa = 34'(r_rd);
      default:  opa = '0;
    endcase
    case (cmd_i.mac.b_sel)
      OPB_AMAG: opb = {4'b0, a_q[cmd_i.mac.bidx][29:0]};
      OPB_UP:   opb = 34'(up_q[cmd_i.mac.bidx]);
      OPB_F:    opb = 34'(f_q[cmd_i.mac.bidx]);
      OPB_S:    opb = 34'(s_q[cmd_i.mac.bidx]);
      OPB_U:    opb = 34'(u_q[cmd_i.mac.bidx]);
      OPB_NEYE: opb = -34'(eye_q[cmd_i.mac.bidx]);
      OPB_ONE:  opb = ONE34;
      default:  opb = '0;
    endcase
  end

  assign mul_w    = opa * opb;
  assign acc_rnd  = (acc_q + HALF68) >>> FRAC_BITS;
  assign prod_rnd = (prod_q + HALF68) >>> FRAC_BITS;
  assign sq_t     = root_q + bit_q;
  assign quo_s    = sgn_q[cmd_i.vidx] ? -$signed(quo_q) : $signed(quo_q);

  // Base matrix resets to identity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) begin
        m_q[k] <= (k == 0 || k == 5 || k == 10 || k == 15) ? ONE32 : 32'sd0;
      end
    end else if (cmd_i.op == DP_IN_LOAD && !in_data_i.mode) begin
      m_q[in_data_i.element_index] <= in_data_i.element_value;
    end else if (cmd_i.op == DP_COPY) begin
      m_q <= r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_IN_LOAD: begin
        if (in_data_i.mode) begin
          eye_q[0] <= in_data_i.eye_x;
          eye_q[1] <= in_data_i.eye_y;
          eye_q[2] <= in_data_i.eye_z;
          up_q[0]  <= in_data_i.up_x;
          up_q[1]  <= in_data_i.up_y;
          up_q[2]  <= in_data_i.up_z;
          v_q[0]   <= 64'(in_data_i.center_x) - 64'(in_data_i.eye_x);
          v_q[1]   <= 64'(in_data_i.center_y) - 64'(in_data_i.eye_y);
          v_q[2]   <= 64'(in_data_i.center_z) - 64'(in_data_i.eye_z);
          degen_q  <= 1'b0;
        end
      end
      DP_NRM_INIT: begin
        for (int i = 0; i < 3; i++) begin
          a_q[i]   <= v_q[i][63] ? 64'(-v_q[i]) : 64'(v_q[i]);
          sgn_q[i] <= v_q[i][63];
        end
      end
      DP_NRM_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (|or_v[63:34])        a_q[i] <= a_q[i] >> 4;
          else if (|or_v[63:30])   a_q[i] <= a_q[i] >> 1;
          else if (or_v[63:25] == '0) a_q[i] <= a_q[i] << 4;
          else                     a_q[i] <= a_q[i] << 1;
        end
      end
      DP_NRM_ZERO: begin
        degen_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (cmd_i.dst_s) s_q[i] <= '0;
          else f_q[i] <= '0;
        end
      end
      DP_MUL: prod_q <= mul_w;
      DP_ACC: begin
        case (cmd_i.mac.acc_op)
          ACC_LOAD:   acc_q <= prod_q;
          ACC_ADD:    acc_q <= acc_q + prod_q;
          ACC_SUB:    acc_q <= acc_q - prod_q;
          ACC_ADDRND: acc_q <= acc_q + prod_rnd;
          default:    acc_q <= acc_q;
        endcase
      end
      DP_LDR: acc_q <= 68'(r_rd);
      DP_WR: begin
        case (cmd_i.mac.wr_sel)
          WR_C:    v_q[cmd_i.mac.aidx] <= acc_q[63:0];
          WR_U:    u_q[cmd_i.mac.aidx] <= acc_rnd[31:0];
          WR_R:    r_q[cmd_i.mac.mat] <= sat32(acc_rnd);
          WR_RT:   r_q[cmd_i.mac.mat] <= sat32(acc_q);
          default: r_q[cmd_i.mac.mat] <= r_q[cmd_i.mac.mat];
        endcase
      end
      DP_SQRT_INIT: begin
        x_q    <= acc_q[63:0];
        root_q <= '0;
        bit_q  <= BIT0;
      end
      DP_SQRT_STEP: begin
        if (x_q >= sq_t) begin
          x_q    <= x_q - sq_t;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      DP_DIV_INIT: begin
        rem_q <= (a_q[cmd_i.vidx] << FRAC_BITS) + (root_q >> 1);
        dsh_q <= root_q << FRAC_BITS;
        quo_q <= '0;
      end
      DP_DIV_STEP: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          quo_q <= {quo_q[30:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      DP_DIV_WR: begin
        if (cmd_i.dst_s) s_q[cmd_i.vidx] <= quo_s;
        else f_q[cmd_i.vidx] <= quo_s;
      end
      DP_EMIT: begin
        out_q.out_index  <= cmd_i.emit_idx;
        out_q.out_value  <= r_rd;
        out_q.degenerate <= degen_q;
        out_q.last       <= (cmd_i.emit_idx == 4'd15);
      end
      default: prod_q <= prod_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/lookat_view_matrix.sv =====
// Timing: a load transaction writes one base-matrix element; the first result of a compute
// transaction waits on the alignment shifts, two normalizations (each a 32-step square root and
// three dividers of FRAC_BITS+1 steps) and 70 products on one shared 34x34 multiplier; the
// wait is shorter when a vector is zero.
// Throughput: the 16 results leave one per cycle unless stalled; the next transaction is taken
// once the last result sits in the output register. Reset (async, active low) loads identity.
// Top level of the look-at view matrix block; depends on lvm_pkg, lvm_ctrl and
// lvm_datapath.
module lookat_view_matrix import lvm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lvm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lvm_out_t out_data_o
);

  // Command and status between the sequencer and the datapath.
  lvm_cmd_t  cmd;
  lvm_stat_t st;

  // The sequencer walks: normalize forward, cross with up, normalize side,
  // rebuild up, multiply base by basis, translate by minus eye, copy back, emit.
  lvm_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .st_i       (st),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Hold all vectors and matrices; the output register parts the result side
  // from the sequencer so a waiting transaction does not block new input.
  lvm_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/lvm_checker.sv =====
// Port-level checks for the look-at view matrix block, bound to the top level.
// Depends on lvm_pkg.
module lvm_checker import lvm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input lvm_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input lvm_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result transaction changed");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.out_index == 4'd15)))
    else $error("last flag does not match index 15");

  a_busy_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode |=> in_stall_o)
    else $error("input taken during a compute run");

  a_stall_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input open before the run finished");

endmodule

bind lookat_view_matrix lvm_checker u_lvm_checker (.*);
